[hdl/tvl_pkg.sv]
// Shared constants, codes and tables for the tank volume block.
`default_nettype none
package tvl_pkg;

    // Default CORDIC iteration count
    localparam int ITERATION_COUNT_DEF = 16;

    // Serial arithmetic unit widths
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SHAPE  = 2'd0,
        REG_RADIUS = 2'd1,
        REG_LENGTH = 2'd2,
        REG_FULL   = 2'd3
    } cfg_reg_t;

    // Tank shape codes
    localparam logic [1:0] SHAPE_HORIZ = 2'd1;
    localparam logic [1:0] SHAPE_VERT  = 2'd2;

    // Saturation limits
    localparam logic [22:0] VOL_MAX  = 23'h7FFFFF;
    localparam logic [15:0] FILL_MAX = 16'hFFFF;

    // Angles in Q30 radians, pi in Q20
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [21:0]        PI_Q20      = 22'd3294199;

    // Divisors
    localparam logic [31:0] CM_DIV    = 32'd10;
    localparam logic [31:0] HORIZ_DIV = 32'd16000000;
    localparam logic [31:0] VERT_DIV  = 32'd1000000;
    localparam logic [31:0] PCT_MUL   = 32'd100;

    // atan(2^-i) in Q30, truncated
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
        30'h00000000, 30'h00000000
    };

endpackage
`default_nettype wire

[hdl/tvl_serial_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module tvl_serial_mul (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tvl_pkg::MUL_A_W-1:0] a,
    input  wire logic [tvl_pkg::MUL_B_W-1:0] b,
    output logic                              done,
    output logic [tvl_pkg::MUL_A_W-1:0]      p
);
    import tvl_pkg::*;

    localparam int CW = $clog2(MUL_B_W);

    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W-1:0] acc_reg;
    logic [MUL_A_W-1:0] a_sh_reg;
    logic [MUL_B_W-1:0] b_sh_reg;
    logic [CW-1:0]      cnt_reg;

    // One partial product per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_sh_reg <= a;
                b_sh_reg <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_sh_reg[0]) begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= a_sh_reg << 1;
                b_sh_reg <= b_sh_reg >> 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

[hdl/tvl_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tvl_serial_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tvl_pkg::DIV_N_W-1:0] n,
    input  wire logic [tvl_pkg::DIV_D_W-1:0] d,
    output logic                              done,
    output logic [tvl_pkg::DIV_N_W-1:0]      q
);
    import tvl_pkg::*;

    localparam int CW = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [CW-1:0]      cnt_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    // Trial subtract of the next dividend bit
    always_comb begin
        trial = {rem_reg, q_reg[DIV_N_W-1]};
        ge    = trial >= {1'b0, d_reg};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                q_reg    <= n;
                d_reg    <= d;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
                q_reg   <= {q_reg[DIV_N_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

[hdl/tank_volume_from_level.sv]
// Tank volume, level and fill percent from a water level reading.
//
// Input word on s_*: level in 1/16 mm. Result word on m_*: volume in 1/16 l,
// level in 1/16 cm and fill in 1/16 percent. Configuration words on cfg_*
// (index 0 shape, 1 radius, 2 length, 3 full volume); cfg_ready is always
// high, write only while no word is in flight.
// One level is processed at a time by a sequencer driving a bit-serial
// multiplier and a bit-serial divider, plus a 24-step square root and
// ITERATION_COUNT CORDIC steps. When the level equals the previous one,
// the held results are repeated.
// The next word is taken only after the result is in the output register;
// s_ready stays high while a result waits on a stalled m_ready, and the next
// result waits in the sequencer until the output register frees up.
// Reset clears the configuration, the held results and the previous level to
// zero, so a first level of zero returns all zeros.
`default_nettype none
module tank_volume_from_level #(
    parameter int ITERATION_COUNT = tvl_pkg::ITERATION_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_level_sixteenth_mm,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [22:0]             m_volume_sixteenth_l,
    output logic [12:0]             m_level_sixteenth_cm,
    output logic [15:0]             m_fill_sixteenth_pct,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire tvl_pkg::cfg_reg_t  cfg_index,
    input  wire logic [19:0]        cfg_data
);
    import tvl_pkg::*;

    localparam int CNT_W = $clog2(ITERATION_COUNT + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV_CM, ST_H_PREP, ST_MUL_D, ST_SQRT, ST_C_INIT, ST_CORDIC,
        ST_C_CLAMP, ST_MUL_RR, ST_MUL_T1, ST_MUL_T2, ST_MUL_AL, ST_V_RR,
        ST_V_RL, ST_V_PI, ST_DIV_VOL, ST_FILL_CHK, ST_MUL_F, ST_DIV_F, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [1:0]  shape_reg;
    logic [11:0] radius_reg;
    logic [12:0] length_reg;
    logic [19:0] full_reg;

    // Held results and output register
    logic [15:0] lvl_reg;
    logic [15:0] prev_reg;
    logic [22:0] vol_reg;
    logic [12:0] cm_reg;
    logic [15:0] fill_reg;
    logic        m_valid_reg;
    logic [22:0] m_vol_reg;
    logic [12:0] m_cm_reg;
    logic [15:0] m_fill_reg;

    // Horizontal datapath
    logic [16:0]        hgt_reg;
    logic signed [17:0] xd_reg;
    logic [47:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]         sq_cnt_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic [CNT_W-1:0]   cd_cnt_reg;
    logic [17:0]        theta_reg;
    logic [49:0]        t1_reg;

    // Serial units
    logic               mul_start_reg;
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic               mul_done;
    logic [MUL_A_W-1:0] mul_p;
    logic               div_start_reg;
    logic [DIV_N_W-1:0] div_n_reg;
    logic [DIV_D_W-1:0] div_d_reg;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    tvl_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    tvl_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .n       (div_n_reg),
        .d       (div_d_reg),
        .done    (div_done),
        .q       (div_q)
    );

    // Square root step
    logic [48:0] sq_sum;
    logic [47:0] sq_n_next, sq_res_next;
    always_comb begin
        sq_sum = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        if ({1'b0, sq_n_reg} >= sq_sum) begin
            sq_n_next   = sq_n_reg - sq_sum[47:0];
            sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
        end else begin
            sq_n_next   = sq_n_reg;
            sq_res_next = sq_res_reg >> 1;
        end
    end

    // CORDIC vectoring step
    logic [4:0]         c_sh;
    logic signed [35:0] c_dx, c_dy, cx_next, cy_next;
    logic signed [34:0] c_at, cz_next;
    always_comb begin
        c_sh = 5'(cd_cnt_reg);
        c_dx = cy_reg >>> c_sh;
        c_dy = cx_reg >>> c_sh;
        c_at = $signed({5'b0, ATAN_Q30[c_sh]});
        if (!cy_reg[35]) begin
            cx_next = cx_reg + c_dx;
            cy_next = cy_reg - c_dy;
            cz_next = cz_reg + c_at;
        end else begin
            cx_next = cx_reg - c_dx;
            cy_next = cy_reg + c_dy;
            cz_next = cz_reg - c_at;
        end
    end

    // Helpers for the horizontal case
    logic [16:0]        two_r;
    logic signed [35:0] x0, y0;
    logic [16:0]        xd_abs;
    logic [48:0]        t2s;
    logic [50:0]        area;
    logic signed [34:0] z_clamp;
    always_comb begin
        two_r  = {radius_reg, 5'b0};
        x0     = {{2{xd_reg[17]}}, xd_reg, 16'b0};
        y0     = {4'b0, sq_res_reg[23:0], 8'b0};
        xd_abs = xd_reg[17] ? 17'(-xd_reg) : xd_reg[16:0];
        t2s    = {mul_p[40:0], 8'b0};
        if (xd_reg[17]) begin
            area = 51'(t1_reg) + 51'(t2s);
        end else if (t1_reg >= 50'(t2s)) begin
            area = 51'(t1_reg - 50'(t2s));
        end else begin
            area = '0;
        end
        if (cz_reg < 0) begin
            z_clamp = '0;
        end else if (cz_reg > PI_Q30) begin
            z_clamp = PI_Q30;
        end else begin
            z_clamp = cz_reg;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            shape_reg     <= '0;
            radius_reg    <= '0;
            length_reg    <= '0;
            full_reg      <= '0;
            prev_reg      <= '0;
            vol_reg       <= '0;
            cm_reg        <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            // configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SHAPE:  shape_reg  <= cfg_data[1:0];
                    REG_RADIUS: radius_reg <= cfg_data[11:0];
                    REG_LENGTH: length_reg <= cfg_data[12:0];
                    REG_FULL:   full_reg   <= cfg_data;
                    default:    ;
                endcase
            end

            // output register
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_vol_reg   <= vol_reg;
                m_cm_reg    <= cm_reg;
                m_fill_reg  <= fill_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        lvl_reg <= s_level_sixteenth_mm;
                        if (s_level_sixteenth_mm == prev_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            div_n_reg     <= DIV_N_W'(s_level_sixteenth_mm);
                            div_d_reg     <= CM_DIV;
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV_CM;
                        end
                    end
                end
                ST_DIV_CM: begin
                    if (div_done) begin
                        cm_reg   <= div_q[12:0];
                        prev_reg <= lvl_reg;
                        if (shape_reg == SHAPE_HORIZ) begin
                            hgt_reg   <= (17'(lvl_reg) > two_r) ? two_r : 17'(lvl_reg);
                            state_reg <= ST_H_PREP;
                        end else if (shape_reg == SHAPE_VERT) begin
                            mul_a_reg     <= MUL_A_W'(radius_reg);
                            mul_b_reg     <= MUL_B_W'(radius_reg);
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_V_RR;
                        end else begin
                            vol_reg   <= '0;
                            state_reg <= ST_FILL_CHK;
                        end
                    end
                end
                ST_H_PREP: begin
                    xd_reg        <= $signed({2'b0, radius_reg, 4'b0})
                                     - $signed({1'b0, hgt_reg});
                    mul_a_reg     <= MUL_A_W'(hgt_reg);
                    mul_b_reg     <= MUL_B_W'(two_r - hgt_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    if (mul_done) begin
                        sq_n_reg   <= {mul_p[31:0], 16'b0};
                        sq_res_reg <= '0;
                        sq_bit_reg <= 48'd1 << 46;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    sq_n_reg   <= sq_n_next;
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd23) begin
                        state_reg <= ST_C_INIT;
                    end
                end
                ST_C_INIT: begin
                    if (xd_reg[17]) begin
                        cx_reg <= y0;
                        cy_reg <= -x0;
                        cz_reg <= HALF_PI_Q30;
                    end else begin
                        cx_reg <= x0;
                        cy_reg <= y0;
                        cz_reg <= '0;
                    end
                    cd_cnt_reg <= '0;
                    state_reg  <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    cx_reg     <= cx_next;
                    cy_reg     <= cy_next;
                    cz_reg     <= cz_next;
                    cd_cnt_reg <= cd_cnt_reg + 1'b1;
                    if (cd_cnt_reg == CNT_W'(ITERATION_COUNT - 1)) begin
                        state_reg <= ST_C_CLAMP;
                    end
                end
                ST_C_CLAMP: begin
                    theta_reg     <= z_clamp[31:14];
                    mul_a_reg     <= MUL_A_W'({radius_reg, 4'b0});
                    mul_b_reg     <= MUL_B_W'({radius_reg, 4'b0});
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_RR;
                end
                ST_MUL_RR: begin
                    if (mul_done) begin
                        mul_a_reg     <= MUL_A_W'(mul_p[31:0]);
                        mul_b_reg     <= MUL_B_W'(theta_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_T1;
                    end
                end
                ST_MUL_T1: begin
                    if (mul_done) begin
                        t1_reg        <= mul_p[49:0];
                        mul_a_reg     <= MUL_A_W'(sq_res_reg[23:0]);
                        mul_b_reg     <= MUL_B_W'(xd_abs);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_T2;
                    end
                end
                ST_MUL_T2: begin
                    if (mul_done) begin
                        mul_a_reg     <= MUL_A_W'(area);
                        mul_b_reg     <= MUL_B_W'(length_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_AL;
                    end
                end
                ST_MUL_AL: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_p >> 16;
                        div_d_reg     <= HORIZ_DIV;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_VOL;
                    end
                end
                ST_V_RR: begin
                    if (mul_done) begin
                        mul_a_reg     <= MUL_A_W'(mul_p[23:0]);
                        mul_b_reg     <= MUL_B_W'(lvl_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_V_RL;
                    end
                end
                ST_V_RL: begin
                    if (mul_done) begin
                        mul_a_reg     <= MUL_A_W'(mul_p[39:0]);
                        mul_b_reg     <= MUL_B_W'(PI_Q20);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_V_PI;
                    end
                end
                ST_V_PI: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_p >> 20;
                        div_d_reg     <= VERT_DIV;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_VOL;
                    end
                end
                ST_DIV_VOL: begin
                    if (div_done) begin
                        vol_reg   <= (|div_q[63:23]) ? VOL_MAX : div_q[22:0];
                        state_reg <= ST_FILL_CHK;
                    end
                end
                ST_FILL_CHK: begin
                    if (full_reg == '0) begin
                        fill_reg  <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        mul_a_reg     <= MUL_A_W'(vol_reg);
                        mul_b_reg     <= PCT_MUL;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_F;
                    end
                end
                ST_MUL_F: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_p;
                        div_d_reg     <= DIV_D_W'(full_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_F;
                    end
                end
                ST_DIV_F: begin
                    if (div_done) begin
                        fill_reg  <= (|div_q[63:16]) ? FILL_MAX : div_q[15:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready              = (state_reg == ST_IDLE);
    assign cfg_ready            = 1'b1;
    assign m_valid              = m_valid_reg;
    assign m_volume_sixteenth_l = m_vol_reg;
    assign m_level_sixteenth_cm = m_cm_reg;
    assign m_fill_sixteenth_pct = m_fill_reg;

endmodule
`default_nettype wire

[hdl/tvl_checker.sv]
// Port-level checks for the tank volume block, bound to the top level.
`default_nettype none
module tvl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [22:0] m_volume_sixteenth_l,
    input wire logic [12:0] m_level_sixteenth_cm,
    input wire logic [15:0] m_fill_sixteenth_pct
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // one word in flight: input closes after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_volume_sixteenth_l)
            && $stable(m_level_sixteenth_cm) && $stable(m_fill_sixteenth_pct))
        else $error("stalled result word changed");

    // level in cm never exceeds the largest 16-bit reading over ten
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_level_sixteenth_cm <= 13'd6553)
        else $error("level in cm out of range");

endmodule

bind tank_volume_from_level tvl_checker u_tvl_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_volume_sixteenth_l (m_volume_sixteenth_l),
    .m_level_sixteenth_cm (m_level_sixteenth_cm),
    .m_fill_sixteenth_pct (m_fill_sixteenth_pct)
);
`default_nettype wire

[verif/tb_tank_volume_from_level.sv]
// Self-checking testbench for the tank volume block: directed table, then random levels.
`default_nettype none
module tb_tank_volume_from_level;
    import tvl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_RANDOM = 850;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_level_sixteenth_mm = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [22:0] m_volume_sixteenth_l;
    logic [12:0] m_level_sixteenth_cm;
    logic [15:0] m_fill_sixteenth_pct;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_reg_t cfg_index = REG_SHAPE;
    logic [19:0] cfg_data = '0;

    tank_volume_from_level uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_level_sixteenth_mm(s_level_sixteenth_mm),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_volume_sixteenth_l(m_volume_sixteenth_l),
        .m_level_sixteenth_cm(m_level_sixteenth_cm),
        .m_fill_sixteenth_pct(m_fill_sixteenth_pct),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    typedef struct packed {
        logic [22:0] vol;
        logic [12:0] cm;
        logic [15:0] fill;
    } tank_reading_t;

    // Predictor copy of configuration and held state
    logic [1:0]  shape_q;
    logic [11:0] radius_q;
    logic [12:0] length_q;
    logic [19:0] full_q;
    logic [15:0] last_level;
    tank_reading_t held;

    tank_reading_t pending_readings[$];
    int errors = 0;
    int cycles = 0;

    // Arithmetic shift right with floor semantics
    function automatic longint sra_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root48(longint unsigned n);
        longint unsigned res, bit_q;
        res = 0;
        bit_q = 64'd1 << 46;
        for (int k = 0; k < 24; k++) begin
            if (n >= res + bit_q) begin
                n = n - (res + bit_q);
                res = (res >> 1) + bit_q;
            end else begin
                res = res >> 1;
            end
            bit_q = bit_q >> 2;
        end
        return res;
    endfunction

    // CORDIC vectoring angle in Q30, clamped to [0, pi]
    function automatic longint segment_angle(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Q30;
        end
        for (int i = 0; i < ITERATION_COUNT_DEF && i < 32; i++) begin
            dx = sra_floor(y, i);
            dy = sra_floor(x, i);
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > PI_Q30) z = PI_Q30;
        return z;
    endfunction

    function automatic longint unsigned horiz_volume(logic [15:0] level);
        longint unsigned r, h, d, s, t1, theta, quot;
        longint xd, area, t2;
        logic [127:0] prod;
        r = longint'(radius_q) * 16;
        h = level;
        if (h > 2 * r) h = 2 * r;
        xd = longint'(r) - longint'(h);
        d = h * (2 * r - h);
        s = root48(d << 16);
        theta = segment_angle(xd * 65536, longint'(s) * 256);
        t1 = r * r * (theta >> 14);
        t2 = xd * longint'(s) * 256;
        area = longint'(t1) - t2;
        if (area < 0) area = 0;
        prod = 128'(area) * 128'(length_q);
        quot = 64'(prod / (128'd16000000 << 16));
        return quot;
    endfunction

    // Expected reading for one level word; updates held state
    function automatic tank_reading_t predict_reading(logic [15:0] level);
        longint unsigned vol, fill;
        logic [127:0] p;
        vol = 0;
        fill = 0;
        if (level != last_level) begin
            if (shape_q == SHAPE_HORIZ) begin
                vol = horiz_volume(level);
            end else if (shape_q == SHAPE_VERT) begin
                p = 128'(radius_q) * 128'(radius_q) * 128'(level) * 128'(PI_Q20);
                vol = 64'(p / (128'd1000000 << 20));
            end
            if (vol > VOL_MAX) vol = VOL_MAX;
            if (full_q != 0) begin
                fill = vol * 100 / full_q;
                if (fill > FILL_MAX) fill = FILL_MAX;
            end
            held.vol = vol[22:0];
            held.cm = 13'(level / 10);
            held.fill = fill[15:0];
            last_level = level;
        end
        return held;
    endfunction

    // Writes follow back to back; setup_tank drops valid after the last one
    task automatic write_reg(cfg_reg_t idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SHAPE:  shape_q = val[1:0];
            REG_RADIUS: radius_q = val[11:0];
            REG_LENGTH: length_q = val[12:0];
            REG_FULL:   full_q = val;
            default:    ;
        endcase
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic setup_tank(logic [1:0] sh, logic [11:0] r, logic [12:0] l,
                              logic [19:0] f);
        wait_drained();
        write_reg(REG_SHAPE, 20'(sh));
        write_reg(REG_RADIUS, 20'(r));
        write_reg(REG_LENGTH, 20'(l));
        write_reg(REG_FULL, f);
        cfg_valid <= 1'b0;
    endtask

    // Send one level word; known != 0 checks the predictor against a typed value.
    // Valid stays high into the next word when no idle cycles are drawn.
    task automatic send_level(logic [15:0] level, bit known, tank_reading_t typed);
        tank_reading_t exp_r;
        int idle;
        idle = $urandom_range(0, 16);
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        exp_r = predict_reading(level);
        if (known && exp_r != typed) begin
            $error("predictor disagrees with table: exp %h got %h", typed, exp_r);
            errors++;
        end
        s_valid <= 1'b1;
        s_level_sixteenth_mm <= level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_readings.push_back(exp_r);
    endtask

    // Result checker with random stalls
    initial begin : result_side
        tank_reading_t e;
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_readings.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_readings.pop_front();
                if (m_volume_sixteenth_l !== e.vol) begin
                    $error("volume_sixteenth_l exp %0d got %0d", e.vol, m_volume_sixteenth_l);
                    errors++;
                end
                if (m_level_sixteenth_cm !== e.cm) begin
                    $error("level_sixteenth_cm exp %0d got %0d", e.cm, m_level_sixteenth_cm);
                    errors++;
                end
                if (m_fill_sixteenth_pct !== e.fill) begin
                    $error("fill_sixteenth_pct exp %0d got %0d", e.fill, m_fill_sixteenth_pct);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] level;
        bit known;
        tank_reading_t typed;
    } level_row_t;

    level_row_t zero_rows[] = '{
        '{16'd0, 1'b1, '0},
        '{16'd0, 1'b1, '0},
        '{16'd65535, 1'b1, '{23'd0, 13'd6553, 16'd0}},
        '{16'd10, 1'b1, '{23'd0, 13'd1, 16'd0}}
    };
    logic [15:0] horiz_levels[] = '{16'd0, 16'd1, 16'd32000, 16'd64000, 16'd64000,
                                    16'd65535, 16'd16000, 16'd48000, 16'd5};
    logic [15:0] vert_levels[] = '{16'd0, 16'd65535, 16'd40000, 16'd1, 16'd12345};

    initial begin : stimulus
        logic [15:0] lvl;
        int mode;
        shape_q = 0; radius_q = 0; length_q = 0; full_q = 0;
        last_level = 0; held = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset: shape zero gives zero volume
        foreach (zero_rows[i]) send_level(zero_rows[i].level, zero_rows[i].known,
                                          zero_rows[i].typed);

        // Horizontal, largest tank
        setup_tank(SHAPE_HORIZ, 12'd4095, 13'd8191, 20'd1048575);
        foreach (horiz_levels[i]) send_level(horiz_levels[i], 1'b0, '0);
        // Horizontal, small radius: level clamped, zero full volume
        setup_tank(SHAPE_HORIZ, 12'd1000, 13'd2000, 20'd0);
        send_level(16'd40000, 1'b0, '0);
        setup_tank(SHAPE_HORIZ, 12'd0, 13'd100, 20'd1);
        send_level(16'd777, 1'b0, '0);
        // Vertical: saturation of fill
        setup_tank(SHAPE_VERT, 12'd4095, 13'd0, 20'd1);
        foreach (vert_levels[i]) send_level(vert_levels[i], 1'b0, '0);
        setup_tank(2'd3, 12'd500, 13'd500, 20'd500);
        send_level(16'd999, 1'b1, '{23'd0, 13'd99, 16'd0});

        // Random phases, each with its own tank
        for (int ph = 0; ph < 10; ph++) begin
            setup_tank(2'($urandom_range(0, 3)), 12'($urandom), 13'($urandom),
                       ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, 3)) : 20'($urandom));
            for (int n = 0; n < N_RANDOM / 10; n++) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) lvl = last_level;
                else if (mode < 3) lvl = 16'($urandom_range(0, 2 * 16 * radius_q + 16));
                else lvl = 16'($urandom);
                send_level(lvl, 1'b0, '0);
                // Hold off until every result is back
                if (n == 20) begin
                    s_valid <= 1'b0;
                    while (pending_readings.size() != 0) @(posedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
